@@ sv/mbus_frame_receiver_core_defines.svh @@
// ----------------------------------------------------------------------------
// mbus frame receiver assertion macros
// concurrent checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MBUS_FRAME_RECEIVER_CORE_DEFINES_SVH
`define MBUS_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication
`define MBFR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbfr check failed");

// next-cycle implication
`define MBFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbfr check failed");

`endif

@@ sv/mbfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mbfr_pkg
// types and constants shared by the m-bus ft1.2 frame receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbfr_pkg;

    localparam logic [7:0] START_SHORT = 8'h10;
    localparam logic [7:0] START_LONG  = 8'h68;
    localparam logic [7:0] STOP_BYTE   = 8'h16;
    localparam logic [7:0] MIN_LEN     = 8'h03;

    localparam logic [1:0] KIND_SHORT   = 2'd0;
    localparam logic [1:0] KIND_CONTROL = 2'd1;
    localparam logic [1:0] KIND_LONG    = 2'd2;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_DATA   = 2'd1;
    localparam logic [1:0] EV_FRAME  = 2'd2;
    localparam logic [1:0] EV_ERROR  = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_L1     = 4'd1,
        PH_L2     = 4'd2,
        PH_START2 = 4'd3,
        PH_C      = 4'd4,
        PH_A      = 4'd5,
        PH_CI     = 4'd6,
        PH_DATA   = 4'd7,
        PH_SUM    = 4'd8,
        PH_STOP   = 4'd9
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] kind;
        logic [7:0] length_field;
        logic [7:0] running_sum;
        logic [7:0] counted_length;
        logic [7:0] data_count;
        logic [7:0] saved_control;
        logic [7:0] saved_address;
        logic [7:0] saved_ci;
    } state_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic [1:0] frame_kind;
        logic [7:0] control_code;
        logic [7:0] station_address;
        logic [7:0] ci_code;
        logic [7:0] frame_length;
    } result_t;

    localparam state_t STATE_CLEAR = '{
        phase:          PH_IDLE,
        kind:           KIND_SHORT,
        length_field:   8'd0,
        running_sum:    8'd0,
        counted_length: 8'd0,
        data_count:     8'd0,
        saved_control:  8'd0,
        saved_address:  8'd0,
        saved_ci:       8'd0
    };

endpackage

`default_nettype wire

@@ sv/mbfr_step.sv @@
// ----------------------------------------------------------------------------
// mbfr_step
// next-state and result logic for one received byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbfr_step
(
    input  var mbfr_pkg::state_t  state_cur,
    input  wire logic [7:0]       rx_byte,
    output var mbfr_pkg::state_t  state_next,
    output var mbfr_pkg::result_t result_next
);

    function automatic logic short_code_ok(input logic [7:0] c);
        logic [7:0] base;
        base = c & 8'hCF;
        return (c == 8'h40) || (base == 8'h4A) || (base == 8'h4B);
    endfunction

    function automatic logic long_code_ok(input logic [7:0] c);
        return (c & 8'hCF) == 8'h43;
    endfunction

    logic       fail;
    logic [7:0] sum_add;
    logic [7:0] count_inc;

    assign sum_add   = state_cur.running_sum + rx_byte;
    assign count_inc = state_cur.counted_length + 8'd1;

    always_comb
    begin
        state_next  = state_cur;
        result_next = '0;
        fail        = 1'b0;
        case (state_cur.phase)
            mbfr_pkg::PH_IDLE:
            begin
                if (rx_byte == mbfr_pkg::START_SHORT)
                begin
                    state_next       = mbfr_pkg::STATE_CLEAR;
                    state_next.kind  = mbfr_pkg::KIND_SHORT;
                    state_next.phase = mbfr_pkg::PH_C;
                end
                else if (rx_byte == mbfr_pkg::START_LONG)
                begin
                    state_next       = mbfr_pkg::STATE_CLEAR;
                    state_next.phase = mbfr_pkg::PH_L1;
                end
            end
            mbfr_pkg::PH_L1:
            begin
                state_next.length_field = rx_byte;
                state_next.kind = (rx_byte == mbfr_pkg::MIN_LEN) ?
                                  mbfr_pkg::KIND_CONTROL : mbfr_pkg::KIND_LONG;
                if (rx_byte < mbfr_pkg::MIN_LEN)
                    fail = 1'b1;
                else
                    state_next.phase = mbfr_pkg::PH_L2;
            end
            mbfr_pkg::PH_L2:
            begin
                if (rx_byte != state_cur.length_field)
                    fail = 1'b1;
                else
                    state_next.phase = mbfr_pkg::PH_START2;
            end
            mbfr_pkg::PH_START2:
            begin
                if (rx_byte != mbfr_pkg::START_LONG)
                    fail = 1'b1;
                else
                    state_next.phase = mbfr_pkg::PH_C;
            end
            mbfr_pkg::PH_C:
            begin
                state_next.running_sum = sum_add;
                if (state_cur.kind == mbfr_pkg::KIND_SHORT)
                begin
                    if (short_code_ok(rx_byte))
                    begin
                        state_next.saved_control = rx_byte;
                        state_next.phase         = mbfr_pkg::PH_A;
                    end
                    else
                        fail = 1'b1;
                end
                else
                begin
                    state_next.counted_length = 8'd1;
                    if (long_code_ok(rx_byte))
                    begin
                        state_next.saved_control = rx_byte;
                        state_next.phase         = mbfr_pkg::PH_A;
                    end
                    else
                        fail = 1'b1;
                end
            end
            mbfr_pkg::PH_A:
            begin
                state_next.running_sum   = sum_add;
                state_next.saved_address = rx_byte;
                if (state_cur.kind == mbfr_pkg::KIND_SHORT)
                    state_next.phase = mbfr_pkg::PH_SUM;
                else
                begin
                    state_next.counted_length = count_inc;
                    state_next.phase          = mbfr_pkg::PH_CI;
                end
            end
            mbfr_pkg::PH_CI:
            begin
                state_next.running_sum = sum_add;
                state_next.saved_ci    = rx_byte;
                if (state_cur.kind == mbfr_pkg::KIND_CONTROL)
                    state_next.phase = mbfr_pkg::PH_SUM;
                else
                begin
                    state_next.counted_length = count_inc;
                    state_next.data_count     = 8'd0;
                    state_next.phase          = mbfr_pkg::PH_DATA;
                end
            end
            mbfr_pkg::PH_DATA:
            begin
                state_next.running_sum    = sum_add;
                state_next.counted_length = count_inc;
                state_next.data_count     = state_cur.data_count + 8'd1;
                result_next.event_res     = mbfr_pkg::EV_DATA;
                result_next.data_byte     = rx_byte;
                result_next.data_index    = state_cur.data_count;
                if (count_inc == state_cur.length_field)
                    state_next.phase = mbfr_pkg::PH_SUM;
            end
            mbfr_pkg::PH_SUM:
            begin
                if (rx_byte != state_cur.running_sum)
                    fail = 1'b1;
                else
                    state_next.phase = mbfr_pkg::PH_STOP;
            end
            mbfr_pkg::PH_STOP:
            begin
                if (rx_byte != mbfr_pkg::STOP_BYTE)
                    fail = 1'b1;
                else
                begin
                    result_next.event_res       = mbfr_pkg::EV_FRAME;
                    result_next.frame_kind      = state_cur.kind;
                    result_next.control_code    = state_cur.saved_control;
                    result_next.station_address = state_cur.saved_address;
                    if (state_cur.kind != mbfr_pkg::KIND_SHORT)
                    begin
                        result_next.ci_code      = state_cur.saved_ci;
                        result_next.frame_length = state_cur.length_field;
                    end
                    state_next.phase = mbfr_pkg::PH_IDLE;
                end
            end
            default:
            begin
                fail = 1'b1;
            end
        endcase

        if (fail)
        begin
            state_next            = mbfr_pkg::STATE_CLEAR;
            result_next           = '0;
            result_next.event_res = mbfr_pkg::EV_ERROR;
        end
    end

endmodule

`default_nettype wire

@@ sv/mbus_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// mbus_frame_receiver_core
// m-bus ft1.2 frame receiver, one byte request in, one result request out
// latency: a result is valid the cycle after its byte is accepted
// throughput: one byte per cycle, held back only by a full output register
// the output register frees itself in the cycle its result is taken
// reset: frame state returns to idle, the output register is empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mbus_frame_receiver_core_defines.svh"

module mbus_frame_receiver_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output wire logic       in_ready,
    input  wire logic [7:0] rx_byte,
    output wire logic       out_valid,
    input  wire logic       out_ready,
    output wire logic [1:0] event_res,
    output wire logic [7:0] data_byte,
    output wire logic [7:0] data_index,
    output wire logic [1:0] frame_kind,
    output wire logic [7:0] control_code,
    output wire logic [7:0] station_address,
    output wire logic [7:0] ci_code,
    output wire logic [7:0] frame_length
);

    mbfr_pkg::state_t  state_reg;
    mbfr_pkg::state_t  state_next;
    mbfr_pkg::result_t result_reg;
    mbfr_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    mbfr_step u_step
    (
        .state_cur   (state_reg),
        .rx_byte     (rx_byte),
        .state_next  (state_next),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbfr_pkg::STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                state_reg <= state_next;
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign event_res       = result_reg.event_res;
    assign data_byte       = result_reg.data_byte;
    assign data_index      = result_reg.data_index;
    assign frame_kind      = result_reg.frame_kind;
    assign control_code    = result_reg.control_code;
    assign station_address = result_reg.station_address;
    assign ci_code         = result_reg.ci_code;
    assign frame_length    = result_reg.frame_length;

    // idle noise is dropped without leaving idle
    `MBFR_ASSERT_NEXT(a_idle_noise, in_fire && state_reg.phase == mbfr_pkg::PH_IDLE && rx_byte != mbfr_pkg::START_SHORT && rx_byte != mbfr_pkg::START_LONG, result_reg.event_res == mbfr_pkg::EV_NONE && state_reg.phase == mbfr_pkg::PH_IDLE)
    // an error clears all frame state
    `MBFR_ASSERT_SAME(a_error_clears, out_valid_reg && result_reg.event_res == mbfr_pkg::EV_ERROR, state_reg == mbfr_pkg::STATE_CLEAR)
    // a delivered frame leaves the receiver idle
    `MBFR_ASSERT_SAME(a_frame_idle, out_valid_reg && result_reg.event_res == mbfr_pkg::EV_FRAME, state_reg.phase == mbfr_pkg::PH_IDLE)
    // data index tracks the data counter
    `MBFR_ASSERT_SAME(a_data_index, out_valid_reg && result_reg.event_res == mbfr_pkg::EV_DATA, state_reg.data_count == 8'(result_reg.data_index + 8'd1) && (state_reg.phase == mbfr_pkg::PH_DATA || state_reg.phase == mbfr_pkg::PH_SUM))

endmodule

`default_nettype wire
